// File: sv/ppv_pkg.sv
// shared constants, types and helpers of the perspective projection unit
`default_nettype none

package ppv_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int QUO_W = 31;
	localparam int DIV_STAGES = QUO_W;
	localparam int POST_STAGES = 4;
	localparam int LATENCY = 1 + DIV_STAGES + POST_STAGES;
	localparam int FRAC_BITS = 12;
	localparam int RND_W = 32 + FRAC_BITS;
	localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(2 ** (FRAC_BITS - 1));
	localparam logic [4:0] FOV_MIN = 5'd8;
	localparam logic [4:0] FOV_MAX = 5'd18;
	localparam logic [4:0] NUM_BIAS = 5'd12;

	typedef enum logic [1:0] {
		REG_FOV_SHIFT = 2'd0,
		REG_CENTER_X  = 2'd1,
		REG_CENTER_Y  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic        zneg;
		logic        zero;
		logic        last;
		logic [4:0]  fov;
	} ppv_side_t;

	function automatic logic signed [31:0] coord_ext(input logic [31:0] v);
		logic signed [31:0] t;
		t = v << (32 - COORD_WIDTH);
		return t >>> (32 - COORD_WIDTH);
	endfunction

endpackage

`default_nettype wire

// File: sv/perspective_project_vertex_unit.sv
// top level of the perspective projection unit
// Projects one view-space vertex per clock: a word is taken at every edge with start high,
// busy never rises, and each result appears on the result ports for one cycle with strobe
// high, after one input stage, a 31-stage divider (one quotient bit per stage) and four
// stages of multiply, rounding and offset. Results leave in input order and cannot be
// held off. Configuration writes take effect at once; the user must make them only while
// no vertex is in flight (not enforced); zero depth gives zero_depth and zero results.
`default_nettype none

module perspective_project_vertex_unit import ppv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] vx,
	input  wire logic [31:0] vy,
	input  wire logic [31:0] vz,
	input  wire logic        last_in,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data,
	output logic             strobe,
	output logic [31:0]      screen_x,
	output logic [31:0]      screen_y,
	output logic [31:0]      inv_depth,
	output logic             zero_depth,
	output logic             last_out
);

	logic [4:0]         fov_shift_q;
	logic [31:0]        center_x_q;
	logic [31:0]        center_y_q;

	logic               accept;
	logic [4:0]         fov_c;
	logic signed [31:0] zs;
	ppv_side_t          side_in;

	logic               valid_s1;
	ppv_side_t          side_s1;
	logic [31:0]        den_s1;
	logic [QUO_W-1:0]   num_s1;

	logic               div_valid;
	ppv_side_t          div_side;
	logic [QUO_W-1:0]   div_quo;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fov_shift_q <= FOV_MIN;
			center_x_q  <= '0;
			center_y_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FOV_SHIFT: fov_shift_q <= wr_data[4:0];
				REG_CENTER_X:  center_x_q  <= wr_data;
				REG_CENTER_Y:  center_y_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (fov_shift_q < FOV_MIN) begin
			fov_c = FOV_MIN;
		end else if (fov_shift_q > FOV_MAX) begin
			fov_c = FOV_MAX;
		end else begin
			fov_c = fov_shift_q;
		end
		zs           = coord_ext(vz);
		side_in.x    = coord_ext(vx);
		side_in.y    = coord_ext(vy);
		side_in.zneg = zs[31];
		side_in.zero = (zs == '0);
		side_in.last = last_in;
		side_in.fov  = fov_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		den_s1  <= zs[31] ? (32'd0 - zs) : zs;
		num_s1  <= QUO_W'(1) << (fov_c + NUM_BIAS);
	end

	ppv_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.side_in   (side_s1),
		.den_in    (den_s1),
		.num_in    (num_s1),
		.valid_out (div_valid),
		.side_out  (div_side),
		.quo_out   (div_quo)
	);

	ppv_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (div_valid),
		.side_in    (div_side),
		.quo_in     (div_quo),
		.center_x   (center_x_q),
		.center_y   (center_y_q),
		.strobe     (strobe),
		.screen_x   (screen_x),
		.screen_y   (screen_y),
		.inv_depth  (inv_depth),
		.zero_depth (zero_depth),
		.last_out   (last_out)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(accept, LATENCY))
		else $error("result word without a vertex taken at the pipeline latency");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && zero_depth) |-> (screen_x == '0 && screen_y == '0 && inv_depth == '0))
		else $error("zero depth word with nonzero results");

	a_last_pass: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_out == $past(last_in, LATENCY)))
		else $error("last flag not carried with its word");

endmodule

`default_nettype wire

// File: sv/ppv_div_stage.sv
// one restoring division step: one quotient bit per stage
`default_nettype none

module ppv_div_stage import ppv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire ppv_side_t        side_in,
	input  wire logic [31:0]      rem_in,
	input  wire logic [31:0]      den_in,
	input  wire logic [QUO_W-1:0] num_in,
	input  wire logic [QUO_W-1:0] quo_in,
	output logic                  valid_s1,
	output ppv_side_t             side_s1,
	output logic [31:0]           rem_s1,
	output logic [31:0]           den_s1,
	output logic [QUO_W-1:0]      num_s1,
	output logic [QUO_W-1:0]      quo_s1
);

	logic [31:0] rs;
	logic        ge;

	always_comb begin
		rs = {rem_in[30:0], num_in[QUO_W-1]};
		ge = (rs >= den_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		den_s1  <= den_in;
		rem_s1  <= ge ? (rs - den_in) : rs;
		num_s1  <= {num_in[QUO_W-2:0], 1'b0};
		quo_s1  <= {quo_in[QUO_W-2:0], ge};
	end

endmodule

`default_nettype wire

// File: sv/ppv_divider.sv
// pipelined divider chain forming the unsigned reciprocal quotient
`default_nettype none

module ppv_divider import ppv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire ppv_side_t        side_in,
	input  wire logic [31:0]      den_in,
	input  wire logic [QUO_W-1:0] num_in,
	output logic                  valid_out,
	output ppv_side_t             side_out,
	output logic [QUO_W-1:0]      quo_out
);

	logic             valid_c [DIV_STAGES+1];
	ppv_side_t        side_c  [DIV_STAGES+1];
	logic [31:0]      rem_c   [DIV_STAGES+1];
	logic [31:0]      den_c   [DIV_STAGES+1];
	logic [QUO_W-1:0] num_c   [DIV_STAGES+1];
	logic [QUO_W-1:0] quo_c   [DIV_STAGES+1];

	assign valid_c[0] = valid_in;
	assign side_c[0]  = side_in;
	assign rem_c[0]   = '0;
	assign den_c[0]   = den_in;
	assign num_c[0]   = num_in;
	assign quo_c[0]   = '0;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		ppv_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_c[i]),
			.side_in  (side_c[i]),
			.rem_in   (rem_c[i]),
			.den_in   (den_c[i]),
			.num_in   (num_c[i]),
			.quo_in   (quo_c[i]),
			.valid_s1 (valid_c[i+1]),
			.side_s1  (side_c[i+1]),
			.rem_s1   (rem_c[i+1]),
			.den_s1   (den_c[i+1]),
			.num_s1   (num_c[i+1]),
			.quo_s1   (quo_c[i+1])
		);
	end

	assign valid_out = valid_c[DIV_STAGES];
	assign side_out  = side_c[DIV_STAGES];
	assign quo_out   = quo_c[DIV_STAGES];

endmodule

`default_nettype wire

// File: sv/ppv_post.sv
// sign fix, multiply, rounding and viewport offset stages
`default_nettype none

module ppv_post import ppv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire ppv_side_t        side_in,
	input  wire logic [QUO_W-1:0] quo_in,
	input  wire logic [31:0]      center_x,
	input  wire logic [31:0]      center_y,
	output logic                  strobe,
	output logic [31:0]           screen_x,
	output logic [31:0]           screen_y,
	output logic [31:0]           inv_depth,
	output logic                  zero_depth,
	output logic                  last_out
);

	logic [31:0]        qmag;
	logic [RND_W-1:0]   rx_sum;
	logic [RND_W-1:0]   ry_sum;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	ppv_side_t          side_s1, side_s2, side_s3;
	logic signed [31:0] q_s1;
	logic signed [63:0] mx_s2, my_s2;
	logic signed [31:0] inv_s2, inv_s3;
	logic [31:0]        px_s3, py_s3;
	logic [31:0]        sx_s4, sy_s4, inv_s4;
	logic               zero_s4, last_s4;

	always_comb begin
		qmag   = {1'b0, quo_in};
		rx_sum = mx_s2[RND_W-1:0] + ROUND_HALF;
		ry_sum = my_s2[RND_W-1:0] + ROUND_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// signed reciprocal
		side_s1 <= side_in;
		q_s1    <= side_in.zneg ? (32'd0 - qmag) : qmag;
		// products and depth shift
		side_s2 <= side_s1;
		mx_s2   <= $signed(side_s1.x) * q_s1;
		my_s2   <= $signed(side_s1.y) * q_s1;
		inv_s2  <= q_s1 >>> (side_s1.fov - FOV_MIN);
		// round and drop fraction
		side_s3 <= side_s2;
		px_s3   <= rx_sum[RND_W-1:FRAC_BITS];
		py_s3   <= ry_sum[RND_W-1:FRAC_BITS];
		inv_s3  <= inv_s2;
		// viewport offset and zero depth
		zero_s4 <= side_s3.zero;
		last_s4 <= side_s3.last;
		sx_s4   <= side_s3.zero ? '0 : (center_x + px_s3);
		sy_s4   <= side_s3.zero ? '0 : (center_y - py_s3);
		inv_s4  <= side_s3.zero ? '0 : inv_s3;
	end

	assign strobe     = valid_s4;
	assign screen_x   = sx_s4;
	assign screen_y   = sy_s4;
	assign inv_depth  = inv_s4;
	assign zero_depth = zero_s4;
	assign last_out   = last_s4;

endmodule

`default_nettype wire
